// ----- hw/rtl/mksd_pkg.sv -----
// ----------------------------------------------------------------------------
// mksd_pkg
// Shared types, symbol codes and reset values of the Morse keying symbol
// decoder.
// ----------------------------------------------------------------------------
package mksd_pkg;

  localparam int WINDOW_COUNT_BITS_DEF = 16;
  localparam int CFG_DATA_W            = 16;
  localparam int CFG_IDX_W             = 2;
  localparam int MAX_RESULTS           = 8;
  localparam int RES_IDX_W             = 3;
  localparam int RES_CNT_W             = 4;
  localparam int LOOKAHEAD             = 4;

  localparam logic [15:0] WINDOW_LENGTH_RST  = 16'd44100;
  localparam logic [15:0] SILENCE_MARGIN_RST = 16'd1000;
  localparam logic [7:0]  SILENCE_LEVEL_RST  = 8'd0;

  // Decoder advances, in units
  localparam logic [3:0] ADV_DOT   = 4'd1;
  localparam logic [3:0] ADV_GAP   = 4'd1;
  localparam logic [3:0] ADV_DASH  = 4'd3;
  localparam logic [3:0] ADV_SPACE = 4'd3;
  localparam logic [3:0] ADV_WORD  = 4'd9;

  typedef enum logic [2:0] {
    SYM_DOT   = 3'd0,
    SYM_DASH  = 3'd1,
    SYM_SPACE = 3'd2,
    SYM_SLASH = 3'd3,
    SYM_END   = 3'd4
  } symbol_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH  = 2'd0,
    CFG_SILENCE_MARGIN = 2'd1,
    CFG_SILENCE_LEVEL  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] sample;
    logic       last_sample;
  } in_t;

  typedef struct packed {
    logic [2:0] symbol;
    logic       last_symbol;
  } out_t;

  typedef struct packed {
    logic [15:0] window_length;
    logic [15:0] silence_margin;
    logic [7:0]  silence_level;
  } cfg_t;

  // Unit lookahead buffer and skip counter
  typedef struct packed {
    logic [3:0] units;
    logic [2:0] fill;
    logic [3:0] skip;
  } dec_t;

  // All symbols caused by one sample
  typedef struct packed {
    logic [MAX_RESULTS-1:0][2:0] sym;
    logic [RES_CNT_W-1:0]        cnt;
  } batch_t;

endpackage

// ----- hw/rtl/morse_keying_symbol_decoder.sv -----
// ----------------------------------------------------------------------------
// morse_keying_symbol_decoder
// Turns a stream of 8-bit audio samples into Morse symbols.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while in_stall_o is low. Samples are grouped into
// windows of window_length samples; a window whose count of silence_level
// samples reaches window_length - silence_margin is a gap unit, otherwise a
// mark unit. A four-unit lookahead decoder turns units into dot, dash, space,
// or space followed by slash for a word gap; last_sample flushes it and
// appends an end symbol, then all counters and decoder state clear. Each
// sample's symbols (zero to eight) are built in the same cycle into a result
// batch; two batches are held, and the output sends one symbol beat per cycle
// while out_stall_i is low. A sample that yields k symbols is sent as k beats,
// and the input stalls only while a second batch is waiting behind the one
// being sent. Configuration writes take effect on the next sample.
module morse_keying_symbol_decoder #(
  parameter int WindowCountBits = mksd_pkg::WINDOW_COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mksd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mksd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mksd_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output mksd_pkg::out_t                     out_data_o
);

  mksd_pkg::cfg_t             cfg_q;
  logic [WindowCountBits-1:0] win_cnt_q, win_cnt_d;
  logic [WindowCountBits-1:0] sil_cnt_q, sil_cnt_d;
  mksd_pkg::dec_t             dec_q, dec_d;
  mksd_pkg::batch_t           new_batch;
  mksd_pkg::batch_t           slot0_q, slot1_q;
  logic                       vld0_q, vld1_q;
  logic [mksd_pkg::RES_IDX_W-1:0] idx_q;

  logic in_accept;
  logic new_vld;
  logic pop;
  logic head_last;
  logic head_done;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length  <= mksd_pkg::WINDOW_LENGTH_RST;
      cfg_q.silence_margin <= mksd_pkg::SILENCE_MARGIN_RST;
      cfg_q.silence_level  <= mksd_pkg::SILENCE_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mksd_pkg::CFG_WINDOW_LENGTH:  cfg_q.window_length  <= cfg_data_i;
        mksd_pkg::CFG_SILENCE_MARGIN: cfg_q.silence_margin <= cfg_data_i;
        mksd_pkg::CFG_SILENCE_LEVEL:  cfg_q.silence_level  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  mksd_step #(
    .WindowCountBits(WindowCountBits)
  ) u_step (
    .cfg_i    (cfg_q),
    .data_i   (in_data_i),
    .win_cnt_i(win_cnt_q),
    .sil_cnt_i(sil_cnt_q),
    .dec_i    (dec_q),
    .win_cnt_o(win_cnt_d),
    .sil_cnt_o(sil_cnt_d),
    .dec_o    (dec_d),
    .batch_o  (new_batch)
  );

  assign in_stall_o = vld1_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign new_vld    = in_accept && (new_batch.cnt != '0);

  assign out_valid_o            = vld0_q;
  assign head_last              = ({1'b0, idx_q} == slot0_q.cnt - 1'b1);
  assign out_data_o.symbol      = slot0_q.sym[idx_q];
  assign out_data_o.last_symbol = head_last;
  assign pop                    = vld0_q && !out_stall_i;
  assign head_done              = pop && head_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cnt_q <= '0;
      sil_cnt_q <= '0;
      dec_q     <= '0;
    end else if (in_accept) begin
      win_cnt_q <= win_cnt_d;
      sil_cnt_q <= sil_cnt_d;
      dec_q     <= dec_d;
    end
  end

  // Batch queue control: head slot feeds the output, second slot holds the next batch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      idx_q  <= '0;
    end else if (head_done) begin
      idx_q <= '0;
      if (vld1_q) begin
        vld0_q <= 1'b1;
        vld1_q <= 1'b0;
      end else begin
        vld0_q <= new_vld;
      end
    end else begin
      if (pop) begin
        idx_q <= idx_q + 1'b1;
      end
      if (new_vld) begin
        if (!vld0_q) begin
          vld0_q <= 1'b1;
        end else begin
          vld1_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_done) begin
      slot0_q <= vld1_q ? slot1_q : new_batch;
    end else if (new_vld) begin
      if (!vld0_q) begin
        slot0_q <= new_batch;
      end else begin
        slot1_q <= new_batch;
      end
    end
  end

  // Assertions
  a_second_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld1_q |-> vld0_q)
    else $error("second batch slot holds data while head slot is empty");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld0_q |-> (slot0_q.cnt != '0) && ({1'b0, idx_q} < slot0_q.cnt))
    else $error("head batch empty or read index past its symbol count");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.last_sample |=>
      (dec_q == '0) && (win_cnt_q == '0) && (sil_cnt_q == '0))
    else $error("decoder state not cleared after end of message");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.symbol == mksd_pkg::SYM_END) |-> out_data_o.last_symbol)
    else $error("end-of-message symbol not marked as last beat");

endmodule

// ----- hw/rtl/mksd_step.sv -----
// ----------------------------------------------------------------------------
// mksd_step
// Next-state and symbol batch logic for one sample: window counting, unit
// push, lookahead decode and end-of-message flush.
// ----------------------------------------------------------------------------
module mksd_step #(
  parameter int WindowCountBits = mksd_pkg::WINDOW_COUNT_BITS_DEF
) (
  input  mksd_pkg::cfg_t               cfg_i,
  input  mksd_pkg::in_t                data_i,
  input  logic [WindowCountBits-1:0]   win_cnt_i,
  input  logic [WindowCountBits-1:0]   sil_cnt_i,
  input  mksd_pkg::dec_t               dec_i,
  output logic [WindowCountBits-1:0]   win_cnt_o,
  output logic [WindowCountBits-1:0]   sil_cnt_o,
  output mksd_pkg::dec_t               dec_o,
  output mksd_pkg::batch_t             batch_o
);

  localparam int CW = WindowCountBits;
  localparam int TW = (CW > 16) ? CW : 16;

  typedef struct packed {
    mksd_pkg::dec_t   ds;
    mksd_pkg::batch_t b;
  } work_t;

  function automatic mksd_pkg::batch_t append(mksd_pkg::batch_t b, logic [2:0] s);
    mksd_pkg::batch_t r;
    r = b;
    if (!b.cnt[mksd_pkg::RES_CNT_W-1]) begin
      r.sym[b.cnt[mksd_pkg::RES_IDX_W-1:0]] = s;
      r.cnt = b.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic work_t decide(work_t w);
    work_t      r;
    logic [3:0] adv;
    logic [3:0] fill_x;
    logic       u1v;
    logic       u3v;
    r      = w;
    u1v    = (w.ds.fill > 3'd1);
    u3v    = (w.ds.fill > 3'd3);
    fill_x = {1'b0, w.ds.fill};
    if (w.ds.units[0] && u1v && w.ds.units[1]) begin
      r.b = append(r.b, mksd_pkg::SYM_DASH);
      adv = mksd_pkg::ADV_DASH;
    end else if (w.ds.units[0] && u1v && !w.ds.units[1]) begin
      r.b = append(r.b, mksd_pkg::SYM_DOT);
      adv = mksd_pkg::ADV_DOT;
    end else if (!w.ds.units[0] && u1v && w.ds.units[1]) begin
      adv = mksd_pkg::ADV_GAP;
    end else if (!w.ds.units[0] && u3v && !w.ds.units[3]) begin
      r.b = append(r.b, mksd_pkg::SYM_SPACE);
      r.b = append(r.b, mksd_pkg::SYM_SLASH);
      adv = mksd_pkg::ADV_WORD;
    end else begin
      r.b = append(r.b, mksd_pkg::SYM_SPACE);
      adv = mksd_pkg::ADV_SPACE;
    end
    if (adv <= fill_x) begin
      r.ds.units = w.ds.units >> adv;
      r.ds.fill  = w.ds.fill - adv[2:0];
    end else begin
      // advance runs past the buffer: drop the rest as future units
      r.ds.skip  = w.ds.skip + (adv - fill_x);
      r.ds.units = '0;
      r.ds.fill  = '0;
    end
    return r;
  endfunction

  logic [TW-1:0] wl_x;
  logic [CW-1:0] eff;
  logic [TW-1:0] thresh;
  logic [CW-1:0] win_inc;
  logic [CW-1:0] sil_inc;
  logic          win_done;
  logic          unit_bit;
  work_t         w;

  always_comb begin
    wl_x = TW'(cfg_i.window_length);
    eff  = wl_x[CW-1:0];
    if (eff == '0) begin
      eff = CW'(1);
    end
    thresh = (TW'(eff) > TW'(cfg_i.silence_margin))
           ? TW'(eff) - TW'(cfg_i.silence_margin) : '0;
  end

  always_comb begin
    win_inc  = win_cnt_i + 1'b1;
    sil_inc  = (data_i.sample == cfg_i.silence_level) ? sil_cnt_i + 1'b1 : sil_cnt_i;
    win_done = (win_inc == eff);
    unit_bit = !(TW'(sil_inc) >= thresh);
  end

  always_comb begin
    w.ds      = dec_i;
    w.b       = '0;
    win_cnt_o = win_done ? '0 : win_inc;
    sil_cnt_o = win_done ? '0 : sil_inc;

    if (win_done) begin
      if (w.ds.skip != '0) begin
        w.ds.skip = w.ds.skip - 1'b1;
      end else begin
        w.ds.units[w.ds.fill[1:0]] = unit_bit;
        w.ds.fill = w.ds.fill + 1'b1;
        if (w.ds.fill == 3'(mksd_pkg::LOOKAHEAD)) begin
          w = decide(w);
        end
      end
    end

    if (data_i.last_sample) begin
      // flush: units past the end count as neither mark nor gap
      for (int i = 0; i < mksd_pkg::LOOKAHEAD; i++) begin
        if (w.ds.fill != '0) begin
          w = decide(w);
        end
      end
      w.b       = append(w.b, mksd_pkg::SYM_END);
      w.ds      = '0;
      win_cnt_o = '0;
      sil_cnt_o = '0;
    end

    dec_o   = w.ds;
    batch_o = w.b;
  end

endmodule
